// ===== hdl/lz4sd_pkg.sv =====
// lz4sd_pkg: shared types and constants of the LZ4 stream decoder.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package lz4sd_pkg;

  // History ring: 16-bit offsets address 64 KiB of recent output
  localparam int unsigned HistAw    = 16;
  localparam int unsigned HistDepth = 1 << HistAw;

  // Request types on the input channel
  localparam logic ReqByte  = 1'b0;
  localparam logic ReqDrain = 1'b1;

  // LZ4 format constants
  localparam logic [3:0] NibbleExt   = 4'hF;   // length nibble that extends
  localparam logic [7:0] ByteExt     = 8'hFF;  // extra length byte that extends
  localparam int unsigned MinMatch   = 4;
  localparam int unsigned MatchExtLen = 15 + MinMatch;

  typedef enum logic [7:0] {
    PhToken   = 8'b0000_0001,
    PhLitExt  = 8'b0000_0010,
    PhLitCopy = 8'b0000_0100,
    PhOfsLo   = 8'b0000_1000,
    PhOfsHi   = 8'b0001_0000,
    PhMatExt  = 8'b0010_0000,
    PhMatCopy = 8'b0100_0000,
    PhFault   = 8'b1000_0000
  } phase_e;

  typedef struct packed {
    logic       en;
    logic [7:0] data;
  } hist_wr_t;

  typedef struct packed {
    logic       byte_taken;
    logic       out_valid;
    logic [7:0] out_byte;
    logic       error;
    logic       at_sequence_start;
  } lz4sd_res_t;

  typedef struct packed {
    logic fault;
    logic token;
  } lz4sd_stat_t;

endpackage

`default_nettype wire

// ===== hdl/lz4sd_if.sv =====
// lz4sd_if: valid/ready channel interfaces of the LZ4 stream decoder.
// Input channel carries requests, output channel carries results. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface lz4sd_in_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] in_byte;

  modport source (output valid, output req_type, output in_byte, input ready);
  modport sink   (input valid, input req_type, input in_byte, output ready);
endinterface

interface lz4sd_out_if;
  logic       valid;
  logic       ready;
  logic       byte_taken;
  logic       out_valid;
  logic [7:0] out_byte;
  logic       error;
  logic       at_sequence_start;

  modport source (output valid, output byte_taken, output out_valid, output out_byte,
                  output error, output at_sequence_start, input ready);
  modport sink   (input valid, input byte_taken, input out_valid, input out_byte,
                  input error, input at_sequence_start, output ready);
endinterface

`default_nettype wire

// ===== hdl/lz4_stream_decoder.sv =====
// lz4_stream_decoder: LZ4 block decompressor, one request in, one result out.
// Depends on lz4sd_pkg, lz4sd_if, lz4sd_seq and lz4sd_history.
//
// Usage
// - in_i (sink): each transfer is a request, either one compressed byte offered
//   (req_type = byte) or a drain tick (req_type = drain). Every request yields
//   exactly one result transfer on out_o.
// - out_o (source): byte_taken tells the source whether the offered byte was
//   consumed (if not, offer it again); out_valid/out_byte carry one decompressed
//   byte; error is sticky after a zero offset or a length overflow;
//   at_sequence_start is high when the next byte taken is a token.
// - Result: registered; it appears on out_o in the cycle after the request transfer.
// - Throughput: one request per cycle while out_o is not stalled. The parser state and
//   the history read for the next match byte are updated at every accepted transfer;
//   the history read is issued ahead, from the post-transfer state, and recent writes
//   are forwarded, so overlapping matches (offset 1 and up) also run at full rate.
// - Stall: the result sits in an output register; a new request is taken while
//   that register is empty or being drained (in_i.ready follows out_o.ready).
// - Reset: parser returns to token phase, error clears. History reads zero for
//   bytes never written, tracked by the write pointer and a wrap flag, so no
//   clearing pass is needed and the block is ready right after reset.
`timescale 1ns / 1ps
`default_nettype none

module lz4_stream_decoder
  import lz4sd_pkg::*;
#(
  parameter int unsigned LEN_BITS = 32
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  lz4sd_in_if.sink   in_i,
  lz4sd_out_if.source out_o
);

  logic              in_ready;
  logic              acc;
  lz4sd_res_t        res;
  lz4sd_res_t        res_q;
  logic              out_vld_q, out_vld_d;
  hist_wr_t          hist_wr;
  logic [HistAw-1:0] ofs_d;
  logic [7:0]        hist_byte;
  lz4sd_stat_t       stat;

  // Output register is free when empty or being taken this cycle
  assign in_ready   = !out_vld_q || out_o.ready;
  assign in_i.ready = in_ready;
  assign acc        = in_i.valid && in_ready;

  lz4sd_seq #(
    .LEN_BITS (LEN_BITS)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .acc_i       (acc),
    .req_type_i  (in_i.req_type),
    .in_byte_i   (in_i.in_byte),
    .hist_byte_i (hist_byte),
    .res_o       (res),
    .wr_o        (hist_wr),
    .ofs_d_o     (ofs_d),
    .stat_o      (stat)
  );

  lz4sd_history u_history (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (hist_wr),
    .ofs_d_i   (ofs_d),
    .rd_byte_o (hist_byte)
  );

  // Result register
  always_comb begin
    out_vld_d = out_vld_q;
    if (acc) begin
      out_vld_d = 1'b1;
    end else if (out_o.ready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      res_q <= res;
    end
  end

  assign out_o.valid             = out_vld_q;
  assign out_o.byte_taken        = res_q.byte_taken;
  assign out_o.out_valid         = res_q.out_valid;
  assign out_o.out_byte          = res_q.out_byte;
  assign out_o.error             = res_q.error;
  assign out_o.at_sequence_start = res_q.at_sequence_start;

`ifndef SYNTHESIS
  // Fault phase is sticky until reset
  a_fault_sticky : assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.fault |=> stat.fault)
    else $error("decoder left fault phase");

  // In fault phase nothing is consumed or produced
  a_fault_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && stat.fault) |-> (!res.byte_taken && !res.out_valid && res.error))
    else $error("activity in fault phase");

  // A held result is never overwritten by a new request
  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !out_o.ready) |-> !acc)
    else $error("request accepted while result stalled");

  // Every output byte is written to history
  a_hist_write : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && res.out_valid) |-> (hist_wr.en && hist_wr.data == res.out_byte))
    else $error("output byte not written to history");

  // A byte offered at a token boundary is always consumed
  a_token_take : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && stat.token && (in_i.req_type == ReqByte)) |-> res.byte_taken)
    else $error("token byte not taken");
`endif

endmodule

`default_nettype wire

// ===== hdl/lz4sd_history.sv =====
// lz4sd_history: 64 KiB output history ring with registered read-ahead and write forwarding.
// Depends on lz4sd_pkg. Unwritten entries read zero via write pointer / wrap tracking.
`timescale 1ns / 1ps
`default_nettype none

module lz4sd_history
  import lz4sd_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire hist_wr_t          wr_i,
  input  wire logic [HistAw-1:0] ofs_d_i,
  output logic [7:0]             rd_byte_o
);

  logic [7:0]        mem [HistDepth];
  logic [HistAw-1:0] wptr_q, wptr_d;
  logic              wrap_q, wrap_d;
  logic [HistAw-1:0] rd_addr;
  logic              filled, fwd;
  logic [7:0]        mem_q;
  logic              fill_q, fwd_q;
  logic [7:0]        fwd_data_q;

  assign wptr_d  = wptr_q + HistAw'(wr_i.en);
  assign wrap_d  = wrap_q | (wr_i.en & (wptr_q == '1));
  // address the next copy will need, seen from the post-edge state
  assign rd_addr = wptr_d - ofs_d_i;
  assign filled  = wrap_d | (rd_addr < wptr_d);
  assign fwd     = wr_i.en & (rd_addr == wptr_q);

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wptr_q] <= wr_i.data;
    end
    mem_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q     <= '0;
      wrap_q     <= 1'b0;
      fill_q     <= 1'b0;
      fwd_q      <= 1'b0;
      fwd_data_q <= '0;
    end else begin
      wptr_q     <= wptr_d;
      wrap_q     <= wrap_d;
      fill_q     <= filled;
      fwd_q      <= fwd;
      fwd_data_q <= wr_i.data;
    end
  end

  assign rd_byte_o = !fill_q ? 8'h00 : (fwd_q ? fwd_data_q : mem_q);

endmodule

`default_nettype wire

// ===== hdl/lz4sd_seq.sv =====
// lz4sd_seq: LZ4 sequence parser (phase, literal/match counts, offset) and result logic.
// Depends on lz4sd_pkg; takes its copy byte from lz4sd_history.
`timescale 1ns / 1ps
`default_nettype none

module lz4sd_seq
  import lz4sd_pkg::*;
#(
  parameter int unsigned LEN_BITS = 32
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              acc_i,
  input  wire logic              req_type_i,
  input  wire logic [7:0]        in_byte_i,
  input  wire logic [7:0]        hist_byte_i,
  output lz4sd_res_t             res_o,
  output hist_wr_t               wr_o,
  output logic [HistAw-1:0]      ofs_d_o,
  output lz4sd_stat_t            stat_o
);

  phase_e              phase_q, phase_d, phase_n;
  logic [LEN_BITS-1:0] lit_q, lit_d, lit_n;
  logic [LEN_BITS-1:0] mat_q, mat_d, mat_n;
  logic [HistAw-1:0]   ofs_q, ofs_d, ofs_n;
  logic [LEN_BITS:0]   lit_sum, mat_sum;
  logic [LEN_BITS:0]   byte_ext;
  logic                taken, ovalid;
  logic [7:0]          obyte;

  // extra length bytes: carry out of LEN_BITS means overflow
  assign byte_ext = {{(LEN_BITS - 7){1'b0}}, in_byte_i};
  assign lit_sum  = {1'b0, lit_q} + byte_ext;
  assign mat_sum  = {1'b0, mat_q} + byte_ext;

  always_comb begin
    phase_n = phase_q;
    lit_n   = lit_q;
    mat_n   = mat_q;
    ofs_n   = ofs_q;
    taken   = 1'b0;
    ovalid  = 1'b0;
    obyte   = 8'h00;
    if (phase_q == PhFault) begin
      phase_n = PhFault;
    end else if (phase_q == PhMatCopy) begin
      if (mat_q != '0) begin
        ovalid = 1'b1;
        obyte  = hist_byte_i;
        mat_n  = mat_q - LEN_BITS'(1);
      end
      if (mat_n == '0) begin
        phase_n = PhToken;
      end
    end else if (req_type_i == ReqByte) begin
      taken = 1'b1;
      case (phase_q)
        PhToken: begin
          lit_n = LEN_BITS'(in_byte_i[7:4]);
          mat_n = LEN_BITS'(in_byte_i[3:0]) + LEN_BITS'(MinMatch);
          if (in_byte_i[7:4] == 4'h0) begin
            phase_n = PhOfsLo;
          end else if (in_byte_i[7:4] == NibbleExt) begin
            phase_n = PhLitExt;
          end else begin
            phase_n = PhLitCopy;
          end
        end
        PhLitExt: begin
          if (lit_sum[LEN_BITS]) begin
            phase_n = PhFault;
          end else begin
            lit_n = lit_sum[LEN_BITS-1:0];
            if (in_byte_i != ByteExt) begin
              phase_n = PhLitCopy;
            end
          end
        end
        PhLitCopy: begin
          ovalid = 1'b1;
          obyte  = in_byte_i;
          if (lit_q != '0) begin
            lit_n = lit_q - LEN_BITS'(1);
          end
          if (lit_n == '0) begin
            phase_n = PhOfsLo;
          end
        end
        PhOfsLo: begin
          ofs_n   = {8'h00, in_byte_i};
          phase_n = PhOfsHi;
        end
        PhOfsHi: begin
          ofs_n = {in_byte_i, ofs_q[7:0]};
          if (ofs_n == '0) begin
            phase_n = PhFault;
          end else if (mat_q == LEN_BITS'(MatchExtLen)) begin
            phase_n = PhMatExt;
          end else begin
            phase_n = PhMatCopy;
          end
        end
        PhMatExt: begin
          if (mat_sum[LEN_BITS]) begin
            phase_n = PhFault;
          end else begin
            mat_n = mat_sum[LEN_BITS-1:0];
            if (in_byte_i != ByteExt) begin
              phase_n = PhMatCopy;
            end
          end
        end
        default: begin
          phase_n = phase_q;
        end
      endcase
    end
  end

  assign phase_d = acc_i ? phase_n : phase_q;
  assign lit_d   = acc_i ? lit_n   : lit_q;
  assign mat_d   = acc_i ? mat_n   : mat_q;
  assign ofs_d   = acc_i ? ofs_n   : ofs_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhToken;
      lit_q   <= '0;
      mat_q   <= '0;
      ofs_q   <= '0;
    end else begin
      phase_q <= phase_d;
      lit_q   <= lit_d;
      mat_q   <= mat_d;
      ofs_q   <= ofs_d;
    end
  end

  assign wr_o.en   = acc_i & ovalid;
  assign wr_o.data = obyte;
  assign ofs_d_o   = ofs_d;

  assign res_o.byte_taken        = taken;
  assign res_o.out_valid         = ovalid;
  assign res_o.out_byte          = obyte;
  assign res_o.error             = (phase_n == PhFault);
  assign res_o.at_sequence_start = (phase_n == PhToken);

  assign stat_o.fault = (phase_q == PhFault);
  assign stat_o.token = (phase_q == PhToken);

endmodule

`default_nettype wire
